// ----- rtl/bld_pkg.sv -----
package bld_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned CP_W = 21;

	// lead byte classes
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] CONT_MASK  = 8'h3F;

	// pending counts
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	// queue entry between front and back
	typedef struct packed {
		logic            cut;
		logic            last;
		logic [CP_W-1:0] cp;
	} bld_entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} bld_q_stat_t;

endpackage

// ----- rtl/bld_in_if.sv -----
interface bld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] piece_byte;
	logic       piece_end;

	modport source(output valid, output piece_byte, output piece_end, input ready);
	modport sink(input valid, input piece_byte, input piece_end, output ready);
endinterface

// ----- rtl/bld_out_if.sv -----
interface bld_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;
	logic       run_end;
	logic       no_data;
	logic       cut_sequence;

	modport source(output valid, output raw_byte, output run_end, output no_data,
		output cut_sequence, input ready);
	modport sink(input valid, input raw_byte, input run_end, input no_data,
		input cut_sequence, output ready);
endinterface

// ----- rtl/byte_level_token_piece_decoder.sv -----
// byte-level token piece decoder
//
// piece channel (sink): one byte of a vocabulary piece per transaction,
// piece_end set on the last byte. bytes are gathered into utf-8 code points
// and mapped back through the byte-level table.
// result channel (source): one output byte per transaction; run_end marks the
// last result of a piece. a piece that ends inside an unfinished sequence
// gives one transaction with no_data and cut_sequence set and raw_byte zero.
// the byte that finishes a code point is registered into the queue, and each
// result from it is then registered into the output register.
// throughput: one piece byte per cycle; the back end sends one result per
// cycle while results are taken, so a code point re-emitted as k bytes holds
// the back end until all k are sent. the queue between front and back absorbs
// that; when it fills, piece.ready drops until the back end catches up.
// reset clears the accumulator, the queue and the output valid at once.
// a stalled result holds its value; the queue keeps taking bytes until full.
module byte_level_token_piece_decoder #(
	parameter int unsigned QUEUE_DEPTH = bld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bld_in_if.sink    piece,
	bld_out_if.source result
);
	import bld_pkg::*;

	// front to back queue signals
	logic        push;
	logic        pop;
	bld_entry_t  wr_entry;
	bld_entry_t  head;
	bld_q_stat_t qstat;

	// front: utf-8 assembly, emits a code point or a cut marker
	bld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.piece    (piece),
		.qstat    (qstat),
		.push     (push),
		.wr_entry (wr_entry)
	);

	// short queue decouples byte intake from multi-byte output
	bld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	// back: table inverse and utf-8 re-encode, one byte per cycle while results are taken
	bld_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue overflow");

	// pop only from a non-empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.valid)
		else $error("queue underflow");

	// a cut marker is always a bare end marker
	a_cut_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.no_data) |->
			(result.run_end && result.cut_sequence && result.raw_byte == 8'h00))
		else $error("malformed cut marker");

	// data results never carry the cut flag
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.no_data) |-> !result.cut_sequence)
		else $error("cut flag on data result");
endmodule

// ----- rtl/bld_queue.sv -----
module bld_queue #(
	parameter int unsigned DEPTH = bld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bld_pkg::bld_entry_t wr_entry,
	input  logic                pop,
	output bld_pkg::bld_entry_t head,
	output bld_pkg::bld_q_stat_t stat
);
	import bld_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bld_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end
endmodule

// ----- rtl/bld_front.sv -----
module bld_front (
	input  logic                 clk,
	input  logic                 arst_n,
	bld_in_if.sink               piece,
	input  bld_pkg::bld_q_stat_t qstat,
	output logic                 push,
	output bld_pkg::bld_entry_t  wr_entry
);
	import bld_pkg::*;

	logic [CP_W-1:0] acc_q, acc_n;
	logic [1:0]      pend_q, pend_n;
	logic            done;
	logic            accept;
	logic [7:0]      b;

	assign b      = piece.piece_byte;
	assign piece.ready = !qstat.full;
	assign accept = piece.valid && piece.ready;

	always_comb begin
		acc_n = acc_q;
		pend_n = pend_q;
		done = 1'b0;
		if (pend_q == PEND_NONE) begin
			if (!b[7]) begin
				acc_n = CP_W'(b);
				done = 1'b1;
			end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				acc_n = CP_W'(b[4:0]);
				pend_n = PEND_ONE;
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				acc_n = CP_W'(b[3:0]);
				pend_n = PEND_TWO;
			end else begin
				acc_n = CP_W'(b[2:0]);
				pend_n = PEND_THREE;
			end
		end else begin
			acc_n = {acc_q[CP_W-7:0], b[5:0]};
			pend_n = pend_q - 2'd1;
			done = (pend_n == PEND_NONE);
		end
	end

	assign push          = accept && (done || piece.piece_end);
	assign wr_entry.cut  = !done;
	assign wr_entry.last = piece.piece_end;
	assign wr_entry.cp   = done ? acc_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= PEND_NONE;
		end else if (accept) begin
			if (piece.piece_end) begin
				acc_q  <= '0;
				pend_q <= PEND_NONE;
			end else begin
				acc_q  <= done ? '0 : acc_n;
				pend_q <= pend_n;
			end
		end
	end
endmodule

// ----- rtl/bld_back.sv -----
module bld_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bld_pkg::bld_entry_t  head,
	input  bld_pkg::bld_q_stat_t qstat,
	output logic                 pop,
	bld_out_if.source            result
);
	import bld_pkg::*;

	logic [1:0]      idx_q;
	logic [1:0]      last_idx;
	logic [CP_W-1:0] cp;
	logic            is_raw;
	logic [7:0]      raw_val;
	logic [7:0]      sel_byte;
	logic [8:0]      off_val;
	logic            load;
	logic            fire;
	logic            valid_q;
	logic [7:0]      byte_q;
	logic            end_q;
	logic            cut_q;

	assign cp      = head.cp;
	assign off_val = cp[8:0] - 9'd162;

	// byte-level table inverse
	always_comb begin
		is_raw  = 1'b1;
		raw_val = cp[7:0];
		if ((cp >= CP_W'(33) && cp <= CP_W'(126)) || (cp >= CP_W'(161) && cp <= CP_W'(172))
				|| (cp >= CP_W'(174) && cp <= CP_W'(255))) begin
			raw_val = cp[7:0];
		end else if (cp >= CP_W'(256) && cp <= CP_W'(288)) begin
			raw_val = cp[7:0];
		end else if (cp >= CP_W'(289) && cp <= CP_W'(322)) begin
			raw_val = off_val[7:0];
		end else if (cp == CP_W'(323)) begin
			raw_val = 8'd173;
		end else begin
			is_raw = 1'b0;
		end
	end

	always_comb begin
		if (head.cut || is_raw || cp < CP_W'(32'h80)) begin
			last_idx = 2'd0;
		end else if (cp < CP_W'(32'h800)) begin
			last_idx = 2'd1;
		end else if (cp < CP_W'(32'h10000)) begin
			last_idx = 2'd2;
		end else begin
			last_idx = 2'd3;
		end
	end

	always_comb begin
		sel_byte = 8'h00;
		if (head.cut) begin
			sel_byte = 8'h00;
		end else if (is_raw) begin
			sel_byte = raw_val;
		end else begin
			case (last_idx)
				2'd0: sel_byte = cp[7:0];
				2'd1: begin
					case (idx_q)
						2'd0:    sel_byte = LEAD2_CODE | {3'b000, cp[10:6]};
						default: sel_byte = CONT_CODE | {2'b00, cp[5:0]};
					endcase
				end
				2'd2: begin
					case (idx_q)
						2'd0:    sel_byte = LEAD3_CODE | {4'h0, cp[15:12]};
						2'd1:    sel_byte = CONT_CODE | {2'b00, cp[11:6]};
						default: sel_byte = CONT_CODE | {2'b00, cp[5:0]};
					endcase
				end
				default: begin
					case (idx_q)
						2'd0:    sel_byte = LEAD4_CODE | {5'h00, cp[20:18]};
						2'd1:    sel_byte = CONT_CODE | {2'b00, cp[17:12]};
						2'd2:    sel_byte = CONT_CODE | {2'b00, cp[11:6]};
						default: sel_byte = CONT_CODE | {2'b00, cp[5:0]};
					endcase
				end
			endcase
		end
	end

	assign load = !valid_q || result.ready;
	assign fire = qstat.valid && load;
	assign pop  = fire && (idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= qstat.valid;
			end
			if (pop) begin
				idx_q <= 2'd0;
			end else if (fire) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= sel_byte;
			end_q  <= head.last && (idx_q == last_idx);
			cut_q  <= head.cut;
		end
	end

	assign result.valid        = valid_q;
	assign result.raw_byte     = byte_q;
	assign result.run_end      = end_q;
	assign result.no_data      = cut_q;
	assign result.cut_sequence = cut_q;
endmodule

// ----- verif/tb_byte_level_token_piece_decoder.sv -----
module tb_byte_level_token_piece_decoder;
	import bld_pkg::*;

	// cycles without any transaction before the run is called hung
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// random piece bytes after the directed table
	localparam int unsigned RANDOM_BYTES = 76;
	// drain time after the last result
	localparam int unsigned DRAIN_CYCLES = 8;

	// one result transaction, field by field
	typedef struct packed {
		logic [7:0] raw_byte;
		logic       run_end;
		logic       no_data;
		logic       cut_sequence;
	} piece_result_t;

	// one row of the directed table; typed rows carry their single result
	typedef struct {
		logic [7:0]    piece_byte;
		logic          piece_end;
		bit            typed;
		piece_result_t result;
	} piece_row_t;

	logic clk;
	logic arst_n;

	bld_in_if  piece_ch ();
	bld_out_if result_ch ();

	byte_level_token_piece_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.piece  (piece_ch),
		.result (result_ch)
	);

	// decoder state as the testbench tracks it
	logic [CP_W-1:0] cp_acc    = '0;
	logic [1:0]      cont_left = PEND_NONE;

	piece_result_t decoded_bytes_due [$];
	piece_row_t    directed_rows [$];
	int unsigned   mismatch_count = 0;
	int unsigned   idle_cycles    = 0;
	int unsigned   bytes_sent     = 0;
	bit            quiet_tail     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// code points that the byte-level table sends back to one raw byte, else -1
	function automatic int unmap_byte_level(input logic [CP_W-1:0] cp);
		if (cp >= 33 && cp <= 126) return int'(cp);
		if (cp >= 161 && cp <= 172) return int'(cp);
		if (cp >= 174 && cp <= 255) return int'(cp);
		if (cp >= 256 && cp <= 288) return int'(cp) - 256;
		if (cp >= 289 && cp <= 322) return int'(cp) - 289 + 127;
		if (cp == 323) return 173;
		return -1;
	endfunction

	// advance the tracked state by one piece byte and list the results it causes
	function automatic void decode_piece_byte(input logic [7:0] b, input logic last,
		output piece_result_t outs [4], output int n);
		logic [7:0]      bytes [4];
		logic [CP_W-1:0] cp;
		logic            finished;
		int              m;
		n = 0;
		cp = '0;
		finished = 1'b0;
		if (cont_left == PEND_NONE) begin
			// lead position: class by the top bits
			if (b < CONT_CODE) begin
				cp = CP_W'(b);
				finished = 1'b1;
			end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				cp_acc = CP_W'(b & ~LEAD2_MASK);
				cont_left = PEND_ONE;
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				cp_acc = CP_W'(b & ~LEAD3_MASK);
				cont_left = PEND_TWO;
			end else begin
				// 4-byte lead, stray continuation or 0xf8-0xff
				cp_acc = CP_W'(b & 8'h07);
				cont_left = PEND_THREE;
			end
		end else begin
			// continuation position: low six bits, whatever the top bits are
			cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == PEND_NONE) begin
				cp = cp_acc;
				finished = 1'b1;
			end
		end
		if (!finished) begin
			if (last) begin
				// piece cut inside a sequence: one empty end marker
				outs[0] = '{8'h00, 1'b1, 1'b1, 1'b1};
				n = 1;
				cp_acc = '0;
				cont_left = PEND_NONE;
			end
			return;
		end
		cp_acc = '0;
		m = unmap_byte_level(cp);
		if (m >= 0) begin
			bytes[0] = m[7:0];
			n = 1;
		end else if (cp < 21'h80) begin
			bytes[0] = cp[7:0];
			n = 1;
		end else if (cp < 21'h800) begin
			bytes[0] = LEAD2_CODE | 8'(cp[10:6]);
			bytes[1] = CONT_CODE | 8'(cp[5:0]);
			n = 2;
		end else if (cp < 21'h10000) begin
			bytes[0] = LEAD3_CODE | 8'(cp[15:12]);
			bytes[1] = CONT_CODE | 8'(cp[11:6]);
			bytes[2] = CONT_CODE | 8'(cp[5:0]);
			n = 3;
		end else begin
			bytes[0] = LEAD4_CODE | 8'(cp[20:18]);
			bytes[1] = CONT_CODE | 8'(cp[17:12]);
			bytes[2] = CONT_CODE | 8'(cp[11:6]);
			bytes[3] = CONT_CODE | 8'(cp[5:0]);
			n = 4;
		end
		for (int k = 0; k < n; k++) begin
			outs[k] = '{bytes[k], last && (k == n - 1), 1'b0, 1'b0};
		end
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void add_row(input logic [7:0] b, input logic e, input bit typed,
		input piece_result_t result);
		piece_row_t row;
		row.piece_byte = b;
		row.piece_end = e;
		row.typed = typed;
		row.result = result;
		directed_rows.push_back(row);
	endfunction

	// one piece transaction, with an optional burst of idle cycles ahead of it
	task automatic push_piece_byte(input logic [7:0] b, input logic e, input bit typed,
		input piece_result_t typed_result);
		piece_result_t outs [4];
		int            n;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			piece_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		piece_ch.valid      <= 1'b1;
		piece_ch.piece_byte <= b;
		piece_ch.piece_end  <= e;
		do @(posedge clk); while (!piece_ch.ready);
		// accepted at this edge: predict now, ahead of the results it causes
		decode_piece_byte(b, e, outs, n);
		if (typed) begin
			decoded_bytes_due.push_back(typed_result);
		end else begin
			for (int k = 0; k < n; k++) decoded_bytes_due.push_back(outs[k]);
		end
		bytes_sent++;
	endtask

	// hold the piece channel off until every predicted result has come out
	task automatic wait_for_decode_drain();
		piece_ch.valid <= 1'b0;
		while (decoded_bytes_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// result ready: random stall bursts, none in the quiet tail
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// compare every result transaction with the oldest prediction
	always @(posedge clk) begin
		piece_result_t got;
		piece_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.raw_byte, result_ch.run_end, result_ch.no_data,
				result_ch.cut_sequence};
			if (decoded_bytes_due.size() == 0) begin
				flag_mismatch($sformatf("result %h with nothing predicted", got));
			end else begin
				want = decoded_bytes_due.pop_front();
				if (got.raw_byte !== want.raw_byte)
					flag_mismatch($sformatf("raw_byte %h, predicted %h",
						got.raw_byte, want.raw_byte));
				if (got.run_end !== want.run_end)
					flag_mismatch($sformatf("run_end %b, predicted %b",
						got.run_end, want.run_end));
				if (got.no_data !== want.no_data)
					flag_mismatch($sformatf("no_data %b, predicted %b",
						got.no_data, want.no_data));
				if (got.cut_sequence !== want.cut_sequence)
					flag_mismatch($sformatf("cut_sequence %b, predicted %b",
						got.cut_sequence, want.cut_sequence));
			end
		end
	end

	// hang detection: cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (piece_ch.valid && piece_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("byte_level_token_piece_decoder regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned     random_start;
		int              len;
		int              cut_at;
		int              n_cp;
		int              kind;
		logic [7:0]      seq [4];
		logic [CP_W-1:0] cp;
		logic            last_cp;
		bit              paused;
		paused = 1'b0;
		arst_n              <= 1'b0;
		piece_ch.valid      <= 1'b0;
		piece_ch.piece_byte <= 8'h00;
		piece_ch.piece_end  <= 1'b0;

		// directed table: byte, end flag, typed, typed result
		add_row(8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}); // zero byte is data
		add_row(8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}); // lone 0xff lead, cut
		add_row(8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b0, 1'b0}); // top ascii, unmapped
		add_row(8'hC4, 1'b0, 1'b0, '0);
		add_row(8'h80, 1'b0, 1'b0, '0);                         // 256 back to byte 0
		add_row(8'hC5, 1'b0, 1'b0, '0);
		add_row(8'h83, 1'b1, 1'b0, '0);                         // 323 back to 173
		add_row(8'hC4, 1'b0, 1'b0, '0);
		add_row(8'hA1, 1'b0, 1'b0, '0);                         // 289 back to 127
		add_row(8'hC2, 1'b0, 1'b0, '0);
		add_row(8'hAD, 1'b0, 1'b0, '0);                         // 173 re-emitted as utf-8
		add_row(8'hE2, 1'b0, 1'b0, '0);
		add_row(8'h82, 1'b0, 1'b0, '0);
		add_row(8'hAC, 1'b1, 1'b0, '0);                         // three bytes out
		add_row(8'hF0, 1'b0, 1'b0, '0);
		add_row(8'h9F, 1'b0, 1'b0, '0);
		add_row(8'h98, 1'b0, 1'b0, '0);
		add_row(8'h80, 1'b1, 1'b0, '0);                         // four bytes out
		add_row(8'hFF, 1'b0, 1'b0, '0);                         // 0xff as 4-byte lead
		add_row(8'h41, 1'b0, 1'b0, '0);                         // non-continuation bytes
		add_row(8'hBF, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b1, 1'b0, '0);
		add_row(8'hE0, 1'b0, 1'b0, '0);
		add_row(8'h80, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}); // cut after two of three
		add_row(8'hC0, 1'b0, 1'b0, '0);
		add_row(8'h80, 1'b1, 1'b0, '0);                         // overlong zero

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_piece_byte(directed_rows[i].piece_byte, directed_rows[i].piece_end,
				directed_rows[i].typed, directed_rows[i].result);
		wait_for_decode_drain();

		// random pieces: mostly well-formed code points with random content,
		// some overlong, some with bad continuations, some noise, some cut short
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			n_cp = $urandom_range(1, 4);
			for (int i = 0; i < n_cp; i++) begin
				kind = $urandom_range(0, 9);
				case (kind)
					0: len = 1;
					1, 2: len = 1;
					3, 4, 9: begin
						len = 2;
						cp = CP_W'($urandom_range(128, 323));
					end
					5, 8: begin
						len = $urandom_range(2, 4);
						cp = CP_W'($urandom_range(0, 32'h1FFFFF));
					end
					6: begin
						len = 3;
						cp = CP_W'($urandom_range(0, 16'hFFFF));
					end
					default: begin
						len = 4;
						cp = CP_W'($urandom_range(0, 32'h1FFFFF));
					end
				endcase
				case (len)
					1: seq[0] = (kind == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, 127));
					2: begin
						seq[0] = LEAD2_CODE | 8'(cp[10:6]);
						seq[1] = CONT_CODE | 8'(cp[5:0]);
					end
					3: begin
						seq[0] = LEAD3_CODE | 8'(cp[15:12]);
						seq[1] = CONT_CODE | 8'(cp[11:6]);
						seq[2] = CONT_CODE | 8'(cp[5:0]);
					end
					default: begin
						// 0xf8-0xff leads decode like 0xf0-0xf7
						seq[0] = LEAD4_CODE | 8'(cp[20:18]) |
							($urandom_range(0, 1) ? 8'h08 : 8'h00);
						seq[1] = CONT_CODE | 8'(cp[17:12]);
						seq[2] = CONT_CODE | 8'(cp[11:6]);
						seq[3] = CONT_CODE | 8'(cp[5:0]);
					end
				endcase
				// broken continuations: random top bits
				if (kind == 8) begin
					for (int k = 1; k < len; k++) seq[k][7:6] = 2'($urandom_range(0, 3));
				end
				last_cp = (i == n_cp - 1);
				cut_at = len;
				if (last_cp && len > 1 && $urandom_range(0, 7) == 0)
					cut_at = $urandom_range(1, len - 1);
				for (int k = 0; k < cut_at; k++)
					push_piece_byte(seq[k], last_cp && (k == cut_at - 1), 1'b0, '0);
			end
			if (!paused && bytes_sent - random_start >= RANDOM_BYTES / 2) begin
				paused = 1'b1;
				wait_for_decode_drain();
			end
			if (bytes_sent - random_start >= (RANDOM_BYTES * 3) / 4) quiet_tail = 1'b1;
		end
		piece_ch.valid <= 1'b0;

		while (decoded_bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("byte_level_token_piece_decoder regression: pass");
		end else begin
			$display("byte_level_token_piece_decoder regression: fail");
		end
		$finish;
	end

endmodule
